// ===== rtl/tlpi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Terrain LOD patch index generator package
// Shared field widths, the queued cell descriptor and the vertex index helper.
// ----------------------------------------------------------------------------
package tlpi_pkg;

  localparam int VERT_W   = 13;
  localparam int LEVEL_W  = 3;
  localparam int MASK_W   = 4;
  localparam int CELL_W   = 6;
  localparam int CFG_W    = 3;
  localparam int LG_ARG_W = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = 3'd4;

  typedef logic [VERT_W-1:0] vert_t;

  // Fan edges in emission order; also the back end's sequencing state.
  typedef enum logic [1:0] {
    EDGE_TOP    = 2'd0,
    EDGE_RIGHT  = 2'd1,
    EDGE_BOTTOM = 2'd2,
    EDGE_LEFT   = 2'd3
  } tlpi_edge_t;

  // Classified cell: all nine vertex indices the triangles may need.
  typedef struct packed {
    logic       bad;
    logic       lvl0;
    logic [3:0] split;
    vert_t      tl;
    vert_t      tr;
    vert_t      bl;
    vert_t      br;
    vert_t      cp;
    vert_t      mt;
    vert_t      mr;
    vert_t      mb;
    vert_t      ml;
  } tlpi_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tlpi_q_status_t;

  // Vertex index of unit row r and unit column c on a side of 2^lg + 1 vertices.
  // Indices are kept modulo 2^VERT_W.
  function automatic vert_t vidx(input vert_t r, input vert_t c,
                                 input logic [LG_ARG_W-1:0] lg);
    vidx = (r << lg) + r + c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tlpi_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Terrain LOD patch index generator channels
// Valid/ready channels for patch cells in and triangles out.
// ----------------------------------------------------------------------------
interface tlpi_in_if;
  import tlpi_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic [MASK_W-1:0]  edge_mask;
  logic [CELL_W-1:0]  cell_row;
  logic [CELL_W-1:0]  cell_col;

  modport source (output valid, level, edge_mask, cell_row, cell_col, input ready);
  modport sink   (input valid, level, edge_mask, cell_row, cell_col, output ready);
endinterface

interface tlpi_out_if;
  import tlpi_pkg::*;

  logic              valid;
  logic              ready;
  logic [VERT_W-1:0] vert_a;
  logic [VERT_W-1:0] vert_b;
  logic [VERT_W-1:0] vert_c;
  logic              bad_request;
  logic              last_tri;

  modport source (output valid, vert_a, vert_b, vert_c, bad_request, last_tri,
                  input ready);
  modport sink   (input valid, vert_a, vert_b, vert_c, bad_request, last_tri,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/tlpi_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Terrain LOD patch index generator front end
// Holds the patch size register, checks each cell and computes its vertices.
// ----------------------------------------------------------------------------
module tlpi_front #(
  parameter int MAX_CELLS_LOG2 = 6
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [tlpi_pkg::CFG_W-1:0] cfg_data,
  tlpi_in_if.sink                        in_ch,
  input  wire tlpi_pkg::tlpi_q_status_t  q_status,
  output logic                           push,
  output tlpi_pkg::tlpi_entry_t          push_entry
);
  import tlpi_pkg::*;

  localparam int LG_W    = $clog2(MAX_CELLS_LOG2 + 1);
  localparam int CMP_W   = (MAX_CELLS_LOG2 + 1 > CELL_W) ? MAX_CELLS_LOG2 + 1 : CELL_W;
  localparam int LCMP_W  = (LG_W > LEVEL_W) ? LG_W : LEVEL_W;

  logic [CFG_W-1:0] cfg_r;
  logic [LG_W-1:0]  lg_eff;
  logic [CMP_W-1:0] cells, lim, r_ext, c_ext;
  logic             bad;
  logic [LG_ARG_W-1:0] lg_arg;
  vert_t            d, h, rt, rm, rb, cl, cm, cr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_data;
    end
  end

  always_comb begin
    if (int'(cfg_r) > MAX_CELLS_LOG2) begin
      lg_eff = LG_W'(MAX_CELLS_LOG2);
    end else begin
      lg_eff = LG_W'(cfg_r);
    end
  end

  assign lg_arg = LG_ARG_W'(lg_eff);
  assign cells  = CMP_W'(1) << lg_eff;
  assign lim    = cells >> in_ch.level;
  assign r_ext  = CMP_W'(in_ch.cell_row);
  assign c_ext  = CMP_W'(in_ch.cell_col);
  assign bad    = (LCMP_W'(in_ch.level) > LCMP_W'(lg_eff)) || (r_ext >= lim) ||
                  (c_ext >= lim);

  // Unit-grid rows and columns of the cell's corners and midpoints.
  assign d  = VERT_W'(1) << in_ch.level;
  assign h  = d >> 1;
  assign rt = VERT_W'(in_ch.cell_row) << in_ch.level;
  assign cl = VERT_W'(in_ch.cell_col) << in_ch.level;
  assign rm = rt + h;
  assign rb = rt + d;
  assign cm = cl + h;
  assign cr = cl + d;

  always_comb begin
    push_entry.bad   = bad;
    push_entry.lvl0  = (in_ch.level == '0);
    push_entry.tl    = vidx(rt, cl, lg_arg);
    push_entry.tr    = vidx(rt, cr, lg_arg);
    push_entry.bl    = vidx(rb, cl, lg_arg);
    push_entry.br    = vidx(rb, cr, lg_arg);
    push_entry.cp    = vidx(rm, cm, lg_arg);
    push_entry.mt    = vidx(rt, cm, lg_arg);
    push_entry.mr    = vidx(rm, cr, lg_arg);
    push_entry.mb    = vidx(rb, cm, lg_arg);
    push_entry.ml    = vidx(rm, cl, lg_arg);
    push_entry.split = '0;
    if (in_ch.level != '0) begin
      push_entry.split[0] = in_ch.edge_mask[0] && (r_ext == '0);
      push_entry.split[1] = in_ch.edge_mask[1] && (c_ext == lim - CMP_W'(1));
      push_entry.split[2] = in_ch.edge_mask[2] && (r_ext == lim - CMP_W'(1));
      push_entry.split[3] = in_ch.edge_mask[3] && (c_ext == '0);
    end
  end

  assign in_ch.ready = !q_status.full;
  assign push        = in_ch.valid && in_ch.ready;

endmodule
`default_nettype wire

// ===== rtl/tlpi_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Terrain LOD patch index generator cell queue
// Two-entry queue of classified cells between the front and back ends.
// ----------------------------------------------------------------------------
module tlpi_queue (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  input  wire tlpi_pkg::tlpi_entry_t    push_entry,
  input  wire logic                     pop,
  output tlpi_pkg::tlpi_entry_t         head,
  output tlpi_pkg::tlpi_q_status_t      status
);
  import tlpi_pkg::*;

  tlpi_entry_t slot_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  assign head         = slot_r[rd_ptr_r];
  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2)
    else $error("cell queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("cell queue popped while empty");
`endif

endmodule
`default_nettype wire

// ===== rtl/tlpi_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Terrain LOD patch index generator back end
// Walks the queued cell edge by edge and emits one triangle per cycle while out_ch is ready.
// ----------------------------------------------------------------------------
module tlpi_back (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire tlpi_pkg::tlpi_entry_t    head,
  input  wire tlpi_pkg::tlpi_q_status_t q_status,
  output logic                          pop,
  tlpi_out_if.source                    out_ch
);
  import tlpi_pkg::*;

  tlpi_edge_t edge_r, edge_nxt;
  logic       half_r, half_nxt;
  logic       load, last;
  vert_t      va, vb, vc, e_start, e_end, e_mid;
  logic       e_split;

  logic       out_valid_r;
  vert_t      va_r, vb_r, vc_r;
  logic       bad_r, last_r;

  assign load = !q_status.empty && (!out_valid_r || out_ch.ready);
  assign pop  = load && last;

  // Next edge and half.
  always_comb begin
    edge_nxt = edge_r;
    half_nxt = half_r;
    if (load) begin
      if (last) begin
        edge_nxt = EDGE_TOP;
        half_nxt = 1'b0;
      end else if (e_split && !half_r) begin
        half_nxt = 1'b1;
      end else begin
        half_nxt = 1'b0;
        case (edge_r)
          EDGE_TOP:    edge_nxt = EDGE_RIGHT;
          EDGE_RIGHT:  edge_nxt = EDGE_BOTTOM;
          EDGE_BOTTOM: edge_nxt = EDGE_LEFT;
          default:     edge_nxt = EDGE_TOP;
        endcase
      end
    end
  end

  // Triangle for the current edge and half.
  always_comb begin
    case (edge_r)
      EDGE_TOP: begin
        e_start = head.tl; e_end = head.tr; e_mid = head.mt; e_split = head.split[0];
      end
      EDGE_RIGHT: begin
        e_start = head.tr; e_end = head.br; e_mid = head.mr; e_split = head.split[1];
      end
      EDGE_BOTTOM: begin
        e_start = head.br; e_end = head.bl; e_mid = head.mb; e_split = head.split[2];
      end
      default: begin
        e_start = head.bl; e_end = head.tl; e_mid = head.ml; e_split = head.split[3];
      end
    endcase

    if (head.bad) begin
      va = '0; vb = '0; vc = '0;
      last = 1'b1;
    end else if (head.lvl0) begin
      // A unit cell is two triangles sharing the bottom-left to top-right diagonal.
      if (edge_r == EDGE_TOP) begin
        va = head.tl; vb = head.tr; vc = head.bl;
      end else begin
        va = head.bl; vb = head.tr; vc = head.br;
      end
      last = (edge_r == EDGE_RIGHT);
    end else begin
      va = head.cp;
      if (!e_split) begin
        vb = e_start; vc = e_end;
      end else if (!half_r) begin
        vb = e_start; vc = e_mid;
      end else begin
        vb = e_mid; vc = e_end;
      end
      last = (edge_r == EDGE_LEFT) && (!e_split || half_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_r      <= EDGE_TOP;
      half_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      edge_r <= edge_nxt;
      half_r <= half_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      va_r   <= va;
      vb_r   <= vb;
      vc_r   <= vc;
      bad_r  <= head.bad;
      last_r <= last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.vert_a      = va_r;
  assign out_ch.vert_b      = vb_r;
  assign out_ch.vert_c      = vc_r;
  assign out_ch.bad_request = bad_r;
  assign out_ch.last_tri    = last_r;

`ifndef NO_ASSERTIONS
  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && bad_r |-> last_r && va_r == '0 && vb_r == '0 && vc_r == '0)
    else $error("bad request result is not a single zero triangle");

  a_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> edge_r == EDGE_TOP && !half_r)
    else $error("sequencer did not restart after the last triangle");
`endif

endmodule
`default_nettype wire

// ===== rtl/terrain_lod_patch_index_gen.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Terrain LOD patch index generator
// Turns patch cells into vertex-index triangles with crack-free edge stitching.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one patch cell per transfer (level, edge_mask, cell_row,
//   cell_col). out_ch carries one triangle per transfer; last_tri marks the
//   final triangle of a cell, bad_request marks the single zero triangle given
//   for a level or cell outside the patch.
//   cfg_we/cfg_data write cells_log2 (patch side is 2^cells_log2 cells);
//   write it only while no cell is in flight.
//   Throughput is one triangle per cycle while out_ch is ready: a cell gives
//   the triangle sequencer 1 (bad), 2 (level 0) or 4 to 8 triangles (one per
//   fan edge, two on a stitched border edge).
//   A transferred cell is written into the cell queue; once the sequencer is
//   free, its first triangle is registered in the output register for out_ch.
//   A two-entry cell queue sits between classification and the sequencer, so
//   cells keep being accepted while triangles wait at the output register.
//   When the receiver stalls, the output holds and the queue fills; in_ch
//   ready drops only when the queue is full.
//   Reset empties the queue and output and sets cells_log2 to 4.
// ----------------------------------------------------------------------------
module terrain_lod_patch_index_gen #(
  parameter int MAX_CELLS_LOG2 = 6
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [tlpi_pkg::CFG_W-1:0] cfg_data,
  tlpi_in_if.sink                         in_ch,
  tlpi_out_if.source                      out_ch
);
  import tlpi_pkg::*;

  tlpi_entry_t    push_entry, head;
  tlpi_q_status_t q_status;
  logic           push, pop;

  tlpi_front #(
    .MAX_CELLS_LOG2 (MAX_CELLS_LOG2)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_ch      (in_ch),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  tlpi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  tlpi_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

// ===== bench/terrain_lod_patch_index_gen_test.sv =====
// ----------------------------------------------------------------------------
// Terrain LOD patch index generator testbench
// Drives patch cells over several patch sizes, expands each accepted cell into
// its expected triangles and checks every triangle transfer in order.
// ----------------------------------------------------------------------------
module terrain_lod_patch_index_gen_test;
  import tlpi_pkg::*;

  localparam int MAX_LG     = 6;
  localparam int LONG_HOLD  = 60;
  localparam int SHOW_LIMIT = 10;
  localparam int PHASE_ITEMS = 56;
  localparam logic [CFG_W-1:0] PHASE_LG [8] = '{3'd3, 3'd6, 3'd1, 3'd7,
                                                3'd5, 3'd0, 3'd2, 3'd4};

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [MASK_W-1:0]  mask;
    logic [CELL_W-1:0]  row;
    logic [CELL_W-1:0]  col;
  } cell_t;

  typedef struct packed {
    vert_t a;
    vert_t b;
    vert_t c;
    logic  bad;
    logic  last;
  } tri_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;

  tlpi_in_if  in_ch ();
  tlpi_out_if out_ch ();

  terrain_lod_patch_index_gen #(
    .MAX_CELLS_LOG2(MAX_LG)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  cell_t            cell_q[$];
  tri_t             pending_tris[$];
  logic [CFG_W-1:0] patch_lg;
  logic             steady;
  logic             cell_fire;
  logic             tri_fire;
  int               hold_requests;
  int               holds_served;
  int               hold_left;
  int               send_gap;
  int               recv_wait;
  int               n_errors;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void emit_tri(input int unsigned a, input int unsigned b,
                                   input int unsigned c);
    tri_t t;
    t.a    = vert_t'(a);
    t.b    = vert_t'(b);
    t.c    = vert_t'(c);
    t.bad  = 1'b0;
    t.last = 1'b0;
    pending_tris = {pending_tris, t};
  endfunction

  // Expands one cell into the triangles it must produce, in emission order.
  function automatic void expand_cell(input cell_t cl);
    int unsigned lg, cells, n, num, d, h, tl, tr, bl, br, cp, p, q, mid;
    logic        split;
    tri_t        t;
    lg    = (patch_lg > MAX_LG) ? MAX_LG : patch_lg;
    cells = 1 << lg;
    n     = cells + 1;
    num   = cells >> cl.level;
    if (cl.level > lg || cl.row >= num || cl.col >= num) begin
      t.a    = '0;
      t.b    = '0;
      t.c    = '0;
      t.bad  = 1'b1;
      t.last = 1'b1;
      pending_tris = {pending_tris, t};
      return;
    end
    if (cl.level == 0) begin
      tl = cl.row * n + cl.col;
      emit_tri(tl, tl + 1, tl + n);
      emit_tri(tl + n, tl + 1, tl + n + 1);
    end else begin
      d  = 1 << cl.level;
      h  = d >> 1;
      tl = cl.row * d * n + cl.col * d;
      tr = tl + d;
      bl = tl + d * n;
      br = bl + d;
      cp = tl + h * n + h;
      for (int e = 0; e < 4; e++) begin
        case (tlpi_edge_t'(e))
          EDGE_TOP: begin
            p = tl; q = tr; mid = tl + h;
            split = (cl.row == 0);
          end
          EDGE_RIGHT: begin
            p = tr; q = br; mid = tr + h * n;
            split = (cl.col == num - 1);
          end
          EDGE_BOTTOM: begin
            p = br; q = bl; mid = bl + h;
            split = (cl.row == num - 1);
          end
          default: begin
            p = bl; q = tl; mid = tl + h * n;
            split = (cl.col == 0);
          end
        endcase
        if (split && cl.mask[e]) begin
          emit_tri(cp, p, mid);
          emit_tri(cp, mid, q);
        end else begin
          emit_tri(cp, p, q);
        end
      end
    end
    t = pending_tris.pop_back();
    t.last = 1'b1;
    pending_tris = {pending_tris, t};
  endfunction

  // Border rows and columns and the first one outside are favored.
  function automatic logic [CELL_W-1:0] pick_coord(input int unsigned num);
    case ($urandom_range(0, 7))
      0: pick_coord = '0;
      1: pick_coord = CELL_W'(num - 1);
      2: pick_coord = CELL_W'(num);
      default: pick_coord = CELL_W'($urandom_range(0, num - 1));
    endcase
  endfunction

  function automatic cell_t rand_cell();
    cell_t       cl;
    int unsigned lg;
    lg      = (patch_lg > MAX_LG) ? MAX_LG : patch_lg;
    cl.mask = MASK_W'($urandom_range(0, 15));
    if ($urandom_range(0, 9) < 2) begin
      cl.level = LEVEL_W'($urandom_range(0, 7));
      cl.row   = CELL_W'($urandom_range(0, 63));
      cl.col   = CELL_W'($urandom_range(0, 63));
    end else begin
      cl.level = LEVEL_W'($urandom_range(0, lg));
      cl.row   = pick_coord((1 << lg) >> cl.level);
      cl.col   = pick_coord((1 << lg) >> cl.level);
    end
    return cl;
  endfunction

  task automatic add_cell(input int level, input int mask, input int row, input int col);
    cell_t cl;
    cl.level = LEVEL_W'(level);
    cl.mask  = MASK_W'(mask);
    cl.row   = CELL_W'(row);
    cl.col   = CELL_W'(col);
    cell_q = {cell_q, cl};
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (cell_q.size() != 0 || in_ch.valid || pending_tris.size() != 0);
  endtask

  task automatic write_lg(input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = value;
    patch_lg = value;
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  // Transfers are sampled at the rising edge, before the block's outputs move.
  always @(posedge clk) begin
    cell_t cl;
    tri_t  got;
    tri_t  want;
    cell_fire = rst_n && in_ch.valid && in_ch.ready;
    tri_fire  = rst_n && out_ch.valid && out_ch.ready;
    if (cell_fire) begin
      cl.level = in_ch.level;
      cl.mask  = in_ch.edge_mask;
      cl.row   = in_ch.cell_row;
      cl.col   = in_ch.cell_col;
      expand_cell(cl);
    end
    if (tri_fire) begin
      got.a    = out_ch.vert_a;
      got.b    = out_ch.vert_b;
      got.c    = out_ch.vert_c;
      got.bad  = out_ch.bad_request;
      got.last = out_ch.last_tri;
      if (pending_tris.size() == 0) begin
        n_errors++;
        if (n_errors <= SHOW_LIMIT)
          $display("unexpected triangle (%0d %0d %0d) bad=%0b last=%0b",
                   got.a, got.b, got.c, got.bad, got.last);
      end else begin
        want = pending_tris.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= SHOW_LIMIT)
            $display("triangle mismatch: expected (%0d %0d %0d) bad=%0b last=%0b, %s",
                     want.a, want.b, want.c, want.bad, want.last,
                     $sformatf("got (%0d %0d %0d) bad=%0b last=%0b",
                               got.a, got.b, got.c, got.bad, got.last));
        end
      end
    end
  end

  // Cell sender: holds an offered cell until its transfer, then idles a while.
  always @(negedge clk) begin
    cell_t cl;
    if (rst_n && !(in_ch.valid && !cell_fire)) begin
      if (send_gap > 0) begin
        in_ch.valid <= 1'b0;
        send_gap--;
      end else if (cell_q.size() != 0) begin
        cl = cell_q.pop_front();
        in_ch.level     <= cl.level;
        in_ch.edge_mask <= cl.mask;
        in_ch.cell_row  <= cl.row;
        in_ch.cell_col  <= cl.col;
        in_ch.valid     <= 1'b1;
        send_gap = steady ? 0 : $urandom_range(0, 7);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Triangle receiver: a random stall after each transfer, plus long hold-offs.
  always @(negedge clk) begin
    if (holds_served < hold_requests) begin
      hold_left = LONG_HOLD;
      holds_served++;
    end
    if (tri_fire)
      recv_wait = steady ? 0 : $urandom_range(0, 7);
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (recv_wait > 0) begin
      out_ch.ready <= 1'b0;
      recv_wait--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.level     = '0;
    in_ch.edge_mask = '0;
    in_ch.cell_row  = '0;
    in_ch.cell_col  = '0;
    out_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    patch_lg        = CFG_RESET;
    steady          = 1'b0;
    cell_fire       = 1'b0;
    tri_fire        = 1'b0;
    hold_requests   = 0;
    holds_served    = 0;
    hold_left       = 0;
    send_gap        = 0;
    recv_wait       = 0;
    n_errors        = 0;
    rst_n           = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Reset patch size of 16 cells: corners, every stitch edge alone and together.
    add_cell(0, 0, 0, 0);
    add_cell(0, 15, 15, 15);
    add_cell(0, 0, 16, 0);
    add_cell(0, 0, 0, 16);
    add_cell(4, 15, 0, 0);
    add_cell(4, 0, 0, 0);
    add_cell(5, 15, 0, 0);
    add_cell(7, 0, 0, 0);
    add_cell(1, 15, 7, 7);
    add_cell(1, 15, 0, 0);
    add_cell(2, 15, 1, 2);
    add_cell(2, 1, 0, 3);
    add_cell(2, 2, 3, 3);
    add_cell(2, 4, 3, 0);
    add_cell(2, 8, 2, 0);
    add_cell(3, 10, 1, 0);
    add_cell(1, 0, 63, 63);
    add_cell(3, 5, 0, 1);
    wait_drained();

    // A zero register leaves a single unit cell.
    write_lg(3'd0);
    add_cell(0, 0, 0, 0);
    add_cell(0, 0, 0, 1);
    add_cell(1, 15, 0, 0);
    wait_drained();

    // An oversized register behaves as the largest patch.
    write_lg(3'd7);
    add_cell(6, 15, 0, 0);
    add_cell(0, 0, 63, 63);
    add_cell(7, 15, 0, 0);
    wait_drained();

    write_lg(3'd6);
    add_cell(0, 15, 63, 63);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      write_lg(PHASE_LG[p]);
      steady = (p == 1 || p == 4);
      // The receiver stalls long enough for the cell queue to fill up.
      if (p == 1)
        hold_requests++;
      repeat (PHASE_ITEMS) cell_q = {cell_q, rand_cell()};
      wait_drained();
    end

    repeat (16) @(negedge clk);
    if (n_errors == 0 && pending_tris.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
